>>> src/utf8_validating_decoder_top_assert.svh
// Assertion macros for the UTF-8 decoder.
`ifndef UTF8_VALIDATING_DECODER_TOP_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset.
`define UVD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("utf8 decoder assertion failed");

// Checked at every edge, reset included.
`define UVD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("utf8 decoder assertion failed");

`else

`define UVD_ASSERT(lbl, clk, rst_n, prop)
`define UVD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> src/utf8vd_pkg.sv
`default_nettype none

package utf8vd_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int LEN_W  = 3;
  localparam int IN_W   = 4 * BYTE_W;
  localparam int OUT_W  = 24;  // CP_W + LEN_W, already whole bytes

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00003F;
  localparam logic [CP_W-1:0] MAX_SCALAR     = 21'h10FFFF;

  typedef struct packed {
    logic [LEN_W-1:0] consumed_len;
    logic [CP_W-1:0]  code_point;
  } result_t;

  function automatic logic is_cont(input logic [BYTE_W-1:0] b);
    return b[7:6] == 2'b10;
  endfunction

endpackage

`default_nettype wire

>>> src/utf8_validating_decoder_top.sv
`default_nettype none
// UTF-8 validating decoder.
// Input stream: one transaction carries a four-byte window that starts at a
// lead byte. Output stream: one transaction per window with the decoded
// code point (0x3F on any invalid sequence) and the number of bytes the
// caller should advance, 1 to 4.
// The window is captured in an input register, decoded by a short block of
// logic, and held in an output register that drives out_tvalid. One window
// per cycle is sustained while out_tready stays high; the rate is set by the
// single decode stage between the two registers.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more window, so in_tready only drops once
// both registers are full and out_tready is low.
// Reset (rst_n low, synchronous) empties both registers; the block keeps no
// other state.
module utf8_validating_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // bytes from [7:0] up: lead, second, third, fourth
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // code_point[20:0], consumed_len[23:21]
);
  import utf8vd_pkg::*;

  logic            s1_valid_r, s1_valid_nxt;
  logic [IN_W-1:0] s1_data_r, s1_data_nxt;
  logic            out_valid_r, out_valid_nxt;
  result_t         out_data_r, out_data_nxt;
  result_t         dec_result;
  logic            adv_out;

  utf8vd_decode u_decode (
    .lead_byte   (s1_data_r[7:0]),
    .second_byte (s1_data_r[15:8]),
    .third_byte  (s1_data_r[23:16]),
    .fourth_byte (s1_data_r[31:24]),
    .result      (dec_result)
  );

  assign adv_out   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv_out;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_data_nxt   = s1_data_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (adv_out) begin
      out_valid_nxt = s1_valid_r;
      out_data_nxt  = dec_result;
    end
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
      s1_data_nxt  = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_data_r  <= s1_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

`include "utf8_validating_decoder_top_assert.svh"

  `UVD_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_tvalid && !s1_valid_r)
  `UVD_ASSERT(a_accept_fills_s1, clk, rst_n, in_tvalid && in_tready |=> s1_valid_r)
  `UVD_ASSERT(a_len_range, clk, rst_n,
    out_tvalid |-> out_tdata[23:21] != 3'd0 && out_tdata[23:21] <= 3'd4)
  `UVD_ASSERT(a_cp_range, clk, rst_n, out_tvalid |-> out_tdata[20:0] <= MAX_SCALAR)
  `UVD_ASSERT(a_len1_small, clk, rst_n,
    out_tvalid && out_tdata[23:21] == 3'd1 |-> out_tdata[20:0] <= 21'h7F)

endmodule

`default_nettype wire

>>> src/utf8vd_decode.sv
`default_nettype none

module utf8vd_decode (
  input  wire logic [7:0]         lead_byte,
  input  wire logic [7:0]         second_byte,
  input  wire logic [7:0]         third_byte,
  input  wire logic [7:0]         fourth_byte,
  output utf8vd_pkg::result_t     result
);
  import utf8vd_pkg::*;

  logic [CP_W-1:0]  cp;
  logic [LEN_W-1:0] len;

  always_comb begin
    cp  = REPLACEMENT_CP;
    len = 3'd1;
    case (lead_byte) inside
      [8'h00:8'h7F]: begin
        cp = {13'd0, lead_byte};
      end
      [8'hC0:8'hDF]: begin
        if (!is_cont(second_byte)) begin
          len = 3'd2;
        end else if (lead_byte >= 8'hC2) begin
          cp  = {10'd0, lead_byte[4:0], second_byte[5:0]};
          len = 3'd2;
        end
        // overlong C0/C1 with a good continuation keeps length 1
      end
      [8'hE0:8'hEF]: begin
        if (!is_cont(second_byte)) begin
          len = 3'd2;
        end else if (!is_cont(third_byte)) begin
          len = 3'd3;
        end else if ((lead_byte == 8'hE0 && second_byte < 8'hA0) ||
                     (lead_byte == 8'hED && second_byte > 8'h9F)) begin
          len = 3'd2;
        end else begin
          cp  = {5'd0, lead_byte[3:0], second_byte[5:0], third_byte[5:0]};
          len = 3'd3;
        end
      end
      [8'hF0:8'hF4]: begin
        if (!is_cont(second_byte)) begin
          len = 3'd2;
        end else if (!is_cont(third_byte)) begin
          len = 3'd3;
        end else if (!is_cont(fourth_byte)) begin
          len = 3'd4;
        end else if ((lead_byte == 8'hF0 && second_byte < 8'h90) ||
                     (lead_byte == 8'hF4 && second_byte > 8'h8F)) begin
          len = 3'd2;
        end else begin
          cp  = {lead_byte[2:0], second_byte[5:0], third_byte[5:0], fourth_byte[5:0]};
          len = 3'd4;
        end
      end
      default: begin
        // stray continuation, F5..FF leads
        cp  = REPLACEMENT_CP;
        len = 3'd1;
      end
    endcase
  end

  always_comb begin
    result.consumed_len = len;
    result.code_point   = (cp > MAX_SCALAR) ? REPLACEMENT_CP : cp;
  end

endmodule

`default_nettype wire

>>> tb/utf8_validating_decoder_top_tb.sv
`timescale 1ns / 100ps

module utf8_validating_decoder_top_tb;
  import utf8vd_pkg::*;

  // Predicts the decoded scalar and advance length per window and keeps them in order
  class scalar_scoreboard;
    result_t expected_scalars[$];
    int      errors;
    int      checked;

    function automatic logic is_tail(input logic [BYTE_W-1:0] b);
      return (b & 8'hC0) == 8'h80;
    endfunction

    function automatic result_t decoded_result(input logic [IN_W-1:0] w);
      logic [BYTE_W-1:0] b0, b1, b2, b3;
      result_t r;
      b0 = w[7:0];
      b1 = w[15:8];
      b2 = w[23:16];
      b3 = w[31:24];
      r.code_point   = REPLACEMENT_CP;
      r.consumed_len = 3'd1;
      if (b0 <= 8'h7F) begin
        r.code_point = {13'd0, b0};
      end else if (b0[7:5] == 3'b110) begin
        if (!is_tail(b1)) begin
          r.consumed_len = 3'd2;
        end else if (b0 >= 8'hC2) begin
          r.code_point   = {10'd0, b0[4:0], b1[5:0]};
          r.consumed_len = 3'd2;
        end
        // C0/C1 with a good tail: overlong, one byte
      end else if (b0[7:4] == 4'hE) begin
        if (!is_tail(b1)) r.consumed_len = 3'd2;
        else if (!is_tail(b2)) r.consumed_len = 3'd3;
        else if ((b0 == 8'hE0 && b1 < 8'hA0) || (b0 == 8'hED && b1 > 8'h9F))
          r.consumed_len = 3'd2;
        else begin
          r.code_point   = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
          r.consumed_len = 3'd3;
        end
      end else if (b0[7:3] == 5'b11110 && b0 <= 8'hF4) begin
        if (!is_tail(b1)) r.consumed_len = 3'd2;
        else if (!is_tail(b2)) r.consumed_len = 3'd3;
        else if (!is_tail(b3)) r.consumed_len = 3'd4;
        else if ((b0 == 8'hF0 && b1 < 8'h90) || (b0 == 8'hF4 && b1 > 8'h8F))
          r.consumed_len = 3'd2;
        else begin
          r.code_point   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
          r.consumed_len = 3'd4;
        end
      end
      if (r.code_point > MAX_SCALAR) r.code_point = REPLACEMENT_CP;
      return r;
    endfunction

    function void note_window(input logic [IN_W-1:0] w);
      expected_scalars.push_back(decoded_result(w));
    endfunction

    function void check_result(input logic [OUT_W-1:0] d);
      result_t got, want;
      got = d;
      checked++;
      if (expected_scalars.size() == 0) begin
        $error("unexpected transaction on output: %h", d);
        errors++;
        return;
      end
      want = expected_scalars.pop_front();
      if (got.code_point !== want.code_point) begin
        $error("code_point: expected %h, actual %h", want.code_point, got.code_point);
        errors++;
      end
      if (got.consumed_len !== want.consumed_len) begin
        $error("consumed_len: expected %0d, actual %0d", want.consumed_len, got.consumed_len);
        errors++;
      end
    endfunction

    function int pending();
      return expected_scalars.size();
    endfunction

    function void flush_leftovers();
      if (expected_scalars.size() != 0) begin
        $error("%0d results never arrived", expected_scalars.size());
        errors += expected_scalars.size();
      end
    endfunction
  endclass

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  scalar_scoreboard sb = new;
  bit steady = 1'b0;  // no idling on either side while set

  always #5 clk = ~clk;

  utf8_validating_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic logic [IN_W-1:0] window(input logic [7:0] b0, b1, b2, b3);
    return {b3, b2, b1, b0};
  endfunction

  function automatic logic [7:0] tail_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) return 8'h00;
    if (pick < 10) return 8'($urandom_range(255));
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // Mostly well-formed sequences with random payload, the rest noise
  function automatic logic [IN_W-1:0] random_window();
    logic [7:0] b0;
    if ($urandom_range(99) < 20) return $urandom;
    case ($urandom_range(5))
      0: b0 = 8'($urandom_range(8'h7F));
      1: b0 = 8'($urandom_range(8'hDF, 8'hC0));
      2: begin
        case ($urandom_range(2))
          0: b0 = 8'hE0;
          1: b0 = 8'hED;
          default: b0 = 8'($urandom_range(8'hEF, 8'hE0));
        endcase
      end
      3: begin
        case ($urandom_range(2))
          0: b0 = 8'hF0;
          1: b0 = 8'hF4;
          default: b0 = 8'($urandom_range(8'hF4, 8'hF0));
        endcase
      end
      4: b0 = ($urandom_range(1) != 0) ? 8'($urandom_range(8'hFF, 8'hF5))
                                       : 8'($urandom_range(8'hBF, 8'h80));
      default: b0 = 8'($urandom_range(255));
    endcase
    return window(b0, tail_byte(), tail_byte(), tail_byte());
  endfunction

  task automatic send_window(input logic [IN_W-1:0] w);
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_window(w);
  endtask

  task automatic pause_input();
    if (!steady && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // Result side: random stalls plus one long hold-off to back up the pipe
  initial begin : result_sink
    int hold_cnt;
    bit hold_done;
    hold_cnt  = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (!hold_done && sb.checked >= 400) begin
        hold_done = 1'b1;
        hold_cnt  = 150;
        out_tready <= 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 9);
      end
    end
  end

  initial begin : stimulus
    logic [IN_W-1:0] directed_windows[$];
    int guard;

    directed_windows = '{
      window(8'h00, 8'h00, 8'h00, 8'h00), window(8'h7F, 8'h80, 8'h80, 8'h80),
      window(8'h80, 8'h80, 8'h80, 8'h80), window(8'hBF, 8'hBF, 8'hBF, 8'hBF),
      window(8'hF8, 8'h80, 8'h80, 8'h80), window(8'hFF, 8'hFF, 8'hFF, 8'hFF),
      window(8'hF5, 8'h80, 8'h80, 8'h80), window(8'hF7, 8'hBF, 8'hBF, 8'hBF),
      window(8'hC0, 8'h80, 8'h00, 8'h00), window(8'hC1, 8'hBF, 8'h00, 8'h00),
      window(8'hC2, 8'h00, 8'h80, 8'h80), window(8'hC2, 8'h80, 8'h00, 8'h00),
      window(8'hDF, 8'hBF, 8'h41, 8'h41), window(8'hE0, 8'h9F, 8'h80, 8'h00),
      window(8'hE0, 8'hA0, 8'h80, 8'h00), window(8'hE1, 8'h41, 8'h80, 8'h80),
      window(8'hE1, 8'h80, 8'h00, 8'h80), window(8'hED, 8'h9F, 8'hBF, 8'h00),
      window(8'hED, 8'hA0, 8'h80, 8'h00), window(8'hEF, 8'hBF, 8'hBF, 8'hFF),
      window(8'hF0, 8'h8F, 8'hBF, 8'hBF), window(8'hF0, 8'h90, 8'h80, 8'h80),
      window(8'hF1, 8'h80, 8'h80, 8'h00), window(8'hF1, 8'h80, 8'hC0, 8'h80),
      window(8'hF4, 8'h8F, 8'hBF, 8'hBF), window(8'hF4, 8'h90, 8'h80, 8'h80)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_windows[i]) begin
      send_window(directed_windows[i]);
      pause_input();
    end

    for (int n = 0; n < 1700; n++) begin
      steady = (n >= 1200 && n < 1450);
      if (n == 800) begin
        // let the pipe drain completely before going on
        in_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      send_window(random_window());
      pause_input();
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (5) @(posedge clk);
    sb.flush_leftovers();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
